// ===== src/keyframe_vec3_linear_interp_macros.svh =====
// assertion macros for the keyframe interpolator
// used by the top level, expects clk and rst_n in scope
`ifndef KEYFRAME_VEC3_LINEAR_INTERP_MACROS_SVH
`define KEYFRAME_VEC3_LINEAR_INTERP_MACROS_SVH

// same-cycle implication
`define KVLI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVLI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/kvli_pkg.sv =====
// shared types and constants of the keyframe interpolator
// no dependencies
package kvli_pkg;

    localparam int MAX_KEYS   = 64;
    localparam int ADDR_W     = 6;
    localparam int KEY_CNT_W  = 7;
    localparam int TIME_W     = 24;
    localparam int VAL_W      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int STATUS_W   = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INTERP     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SINGLE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLAMP_LOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CLAMP_HIGH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WRITE_DONE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WRITE_BAD  = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0] key_time;
        logic [VAL_W-1:0]  x;
        logic [VAL_W-1:0]  y;
        logic [VAL_W-1:0]  z;
    } key_entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        key_entry_t        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [FRAC_BITS-1:0] quot;
    } div_rsp_t;

endpackage

// ===== src/kvli_key_mem.sv =====
// keyframe table: one write port, one registered read port
// depends on kvli_pkg
module kvli_key_mem
(
    input  logic                clk,
    input  kvli_pkg::mem_req_t  req,
    output kvli_pkg::key_entry_t rdata
);

    kvli_pkg::key_entry_t mem [kvli_pkg::MAX_KEYS];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

// ===== src/kvli_div.sv =====
// restoring divider for the blend factor, one quotient bit per cycle
// depends on kvli_pkg; numerator is below the denominator
module kvli_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  kvli_pkg::div_req_t req,
    output kvli_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(kvli_pkg::FRAC_BITS + 1);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [kvli_pkg::TIME_W:0]     rem_reg, rem_next;
    logic [kvli_pkg::TIME_W-1:0]   den_reg, den_next;
    logic [kvli_pkg::FRAC_BITS-1:0] q_reg, q_next;
    logic [kvli_pkg::TIME_W:0]     rem_sh;
    logic                          done_reg, done_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[kvli_pkg::TIME_W-1:0], 1'b0};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = {1'b0, req.num};
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sh - {1'b0, den_reg};
                q_next   = {q_reg[kvli_pkg::FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                q_next   = {q_reg[kvli_pkg::FRAC_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(kvli_pkg::FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

// ===== src/keyframe_vec3_linear_interp.sv =====
// channel   dir  signals                            contents
// s_axis    in   tvalid tready tdata[127:0] tuser   write or query transaction
// m_axis    out  tvalid tready tdata[103:0] tuser   interpolated vector and status
// key_count in   key_count_we key_count_wdata[6:0]  number of valid keys
//
// a write goes from idle straight to the emit state; a query for n keys reads up to n keys:
// one table read per key in the scan, the divider when needed, then a multiply and an add per component
// reset clears control state only; table contents are undefined until written
// a finished result waits in the output register while the next transaction runs,
// only the final load stalls when that register is still full
//
// top level of the keyframe interpolator: sequencer, blend and output register
// depends on kvli_pkg, kvli_key_mem, kvli_div and the assertion macro header
`include "keyframe_vec3_linear_interp_macros.svh"

module keyframe_vec3_linear_interp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          key_count_we,
    input  logic [kvli_pkg::KEY_CNT_W-1:0] key_count_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // key_index[5:0], time_ticks[29:6], value_x[61:30], value_y[93:62],
    // value_z[125:94], zero fill
    input  logic [127:0]                  s_axis_tdata,
    // opcode
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], segment[101:96], zero fill
    output logic [103:0]                  m_axis_tdata,
    // status
    output logic [2:0]                    m_axis_tuser
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIRST = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;

    localparam int AW  = kvli_pkg::ADDR_W;
    localparam int TW  = kvli_pkg::TIME_W;
    localparam int VW  = kvli_pkg::VAL_W;
    localparam int FW  = kvli_pkg::FRAC_BITS;
    localparam int CW  = kvli_pkg::KEY_CNT_W;
    localparam int PW  = VW + 1 + FW + 1;

    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           kc_reg;
    logic [CW-1:0]           n_reg, n_next;
    logic [AW-1:0]           i_reg, i_next;
    logic [1:0]              c_reg, c_next;
    logic [TW-1:0]           t_reg, t_next;
    logic [FW-1:0]           f_reg, f_next;
    kvli_pkg::key_entry_t    prev_reg, prev_next;
    kvli_pkg::key_entry_t    cur_reg, cur_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic [VW-1:0]           rx_reg, rx_next, ry_reg, ry_next, rz_reg, rz_next;
    logic [AW-1:0]           seg_reg, seg_next;
    logic [2:0]              st_reg, st_next;
    logic                    ov_reg, ov_next;
    logic [103:0]            od_reg, od_next;
    logic [2:0]              ou_reg, ou_next;

    kvli_pkg::mem_req_t      mem_req;
    kvli_pkg::key_entry_t    rdata;
    kvli_pkg::div_req_t      div_req;
    kvli_pkg::div_rsp_t      div_rsp;

    logic                    in_fire;
    logic [AW-1:0]           in_idx;
    logic [TW-1:0]           in_time;
    logic [CW-1:0]           n_clamp;
    logic [VW-1:0]           comp_a, comp_b;
    logic signed [VW:0]      diff;
    logic signed [PW-1:0]    prod_sh;
    logic [VW-1:0]           blend;

    kvli_key_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    kvli_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_idx        = s_axis_tdata[5:0];
    assign in_time       = s_axis_tdata[29:6];
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;

    always_comb
    begin
        if (kc_reg == '0)
        begin
            n_clamp = CW'(1);
        end
        else if (kc_reg > CW'(kvli_pkg::MAX_KEYS))
        begin
            n_clamp = CW'(kvli_pkg::MAX_KEYS);
        end
        else
        begin
            n_clamp = kc_reg;
        end
    end

    always_comb
    begin
        case (c_reg)
            2'd0:    begin comp_a = prev_reg.x; comp_b = cur_reg.x; end
            2'd1:    begin comp_a = prev_reg.y; comp_b = cur_reg.y; end
            default: begin comp_a = prev_reg.z; comp_b = cur_reg.z; end
        endcase
    end

    assign diff    = $signed({comp_b[VW-1], comp_b}) - $signed({comp_a[VW-1], comp_a});
    assign prod_sh = prod_reg >>> FW;
    assign blend   = comp_a + prod_sh[VW-1:0];

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        c_next     = c_reg;
        t_next     = t_reg;
        f_next     = f_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        prod_next  = prod_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        rz_next    = rz_reg;
        seg_next   = seg_reg;
        st_next    = st_reg;
        ov_next    = ov_reg && !m_axis_tready;
        od_next    = od_reg;
        ou_next    = ou_reg;

        mem_req.we          = 1'b0;
        mem_req.waddr       = in_idx;
        mem_req.wdata.key_time = in_time;
        mem_req.wdata.x     = s_axis_tdata[61:30];
        mem_req.wdata.y     = s_axis_tdata[93:62];
        mem_req.wdata.z     = s_axis_tdata[125:94];
        mem_req.re          = 1'b0;
        mem_req.raddr       = '0;

        div_req.start = 1'b0;
        div_req.num   = t_reg - prev_reg.key_time;
        div_req.den   = rdata.key_time - prev_reg.key_time;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    t_next = in_time;
                    if (s_axis_tuser == kvli_pkg::OP_WRITE)
                    begin
                        rx_next  = '0;
                        ry_next  = '0;
                        rz_next  = '0;
                        seg_next = in_idx;
                        if ({1'b0, in_idx} >= (AW + 1)'(kvli_pkg::MAX_KEYS))
                        begin
                            st_next = kvli_pkg::ST_WRITE_BAD;
                        end
                        else
                        begin
                            mem_req.we = 1'b1;
                            st_next    = kvli_pkg::ST_WRITE_DONE;
                        end
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        n_next        = n_clamp;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = '0;
                        state_next    = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                prev_next = rdata;
                rx_next   = rdata.x;
                ry_next   = rdata.y;
                rz_next   = rdata.z;
                seg_next  = '0;
                if (n_reg == CW'(1))
                begin
                    st_next    = kvli_pkg::ST_SINGLE;
                    state_next = S_EMIT;
                end
                else if (t_reg < rdata.key_time)
                begin
                    st_next    = kvli_pkg::ST_CLAMP_LOW;
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = AW'(1);
                    i_next        = AW'(1);
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (t_reg < rdata.key_time)
                begin
                    cur_next = rdata;
                    seg_next = i_reg - 1'b1;
                    st_next  = kvli_pkg::ST_INTERP;
                    c_next   = '0;
                    if ((rdata.key_time > prev_reg.key_time) && (t_reg > prev_reg.key_time))
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        f_next     = '0;
                        state_next = S_MUL;
                    end
                end
                else if ({1'b0, i_reg} == n_reg - 1'b1)
                begin
                    rx_next    = rdata.x;
                    ry_next    = rdata.y;
                    rz_next    = rdata.z;
                    seg_next   = i_reg;
                    st_next    = kvli_pkg::ST_CLAMP_HIGH;
                    state_next = S_EMIT;
                end
                else
                begin
                    prev_next     = rdata;
                    mem_req.re    = 1'b1;
                    mem_req.raddr = i_reg + 1'b1;
                    i_next        = i_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    f_next     = div_rsp.quot;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = PW'(diff) * PW'($signed({1'b0, f_reg}));
                state_next = S_ADD;
            end
            S_ADD:
            begin
                case (c_reg)
                    2'd0:    rx_next = blend;
                    2'd1:    ry_next = blend;
                    default: rz_next = blend;
                endcase
                if (c_reg == 2'd2)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    ov_next    = 1'b1;
                    od_next    = {2'b00, seg_reg, rz_reg, ry_reg, rx_reg};
                    ou_next    = st_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kc_reg    <= CW'(1);
            ov_reg    <= 1'b0;
            n_reg     <= CW'(1);
            i_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            c_reg     <= c_next;
            if (key_count_we)
            begin
                kc_reg <= key_count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        f_reg    <= f_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        prod_reg <= prod_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        rz_reg   <= rz_next;
        seg_reg  <= seg_next;
        st_reg   <= st_next;
        od_reg   <= od_next;
        ou_reg   <= ou_next;
    end

    `KVLI_ASSERT_NXT(a_busy_after_accept, in_fire, !s_axis_tready, "accepted while busy")
    `KVLI_ASSERT_IMP(a_write_in_idle, mem_req.we, state_reg == S_IDLE, "table write outside idle")
    `KVLI_ASSERT_IMP(a_div_done_state, div_rsp.done, state_reg == S_DIV, "divider done unexpected")
    `KVLI_ASSERT_IMP(a_scan_bound, state_reg == S_SCAN, {1'b0, i_reg} < n_reg, "scan past key count")

endmodule

// ===== tb/keyframe_vec3_linear_interp_tb.sv =====
// self-checking testbench for the keyframe interpolator: directed table, then random traffic
// a predictor with its own key table checks every result in order; depends on kvli_pkg
`timescale 1ns / 1ps

module keyframe_vec3_linear_interp_tb;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [5:0]  seg;
        logic [2:0]  status;
    } interp_result_t;

    typedef struct {
        logic        op;
        logic [5:0]  idx;
        logic [23:0] t;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        has_exp;
        logic [2:0]  exp_status;
        logic [5:0]  exp_seg;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic key_count_we = 1'b0;
    logic [kvli_pkg::KEY_CNT_W-1:0] key_count_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    keyframe_vec3_linear_interp dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .key_count_we(key_count_we),
        .key_count_wdata(key_count_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #5 clk = ~clk;

    logic [23:0] key_time_tbl [kvli_pkg::MAX_KEYS];
    logic [31:0] key_x_tbl [kvli_pkg::MAX_KEYS];
    logic [31:0] key_y_tbl [kvli_pkg::MAX_KEYS];
    logic [31:0] key_z_tbl [kvli_pkg::MAX_KEYS];
    int unsigned active_keys = 1;

    interp_result_t expected_q[$];
    int mismatch_count = 0;
    bit quiet_phase = 0;
    bit hold_long = 0;
    bit ingress_done = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic logic [31:0] blend_comp(input logic [31:0] a, input logic [31:0] b,
                                               input logic [16:0] f);
        logic signed [63:0] d;
        logic signed [63:0] p;
        d = $signed({{32{b[31]}}, b}) - $signed({{32{a[31]}}, a});
        p = d * $signed({47'd0, f});
        return a + 32'(p >>> kvli_pkg::FRAC_BITS);
    endfunction

    function automatic interp_result_t key_result(input int k, input logic [2:0] st);
        interp_result_t r;
        r.x = key_x_tbl[k];
        r.y = key_y_tbl[k];
        r.z = key_z_tbl[k];
        r.seg = 6'(k);
        r.status = st;
        return r;
    endfunction

    function automatic interp_result_t predict_interp(input logic op, input logic [5:0] idx,
        input logic [23:0] t, input logic [31:0] vx, input logic [31:0] vy,
        input logic [31:0] vz);
        interp_result_t r;
        int n;
        int seg;
        logic [23:0] ts;
        logic [23:0] te;
        logic [16:0] f;
        r = '0;
        if (op == kvli_pkg::OP_WRITE)
        begin
            r.seg = idx;
            r.status = kvli_pkg::ST_WRITE_DONE;
            key_time_tbl[idx] = t;
            key_x_tbl[idx] = vx;
            key_y_tbl[idx] = vy;
            key_z_tbl[idx] = vz;
            return r;
        end
        n = active_keys == 0 ? 1 : (active_keys > kvli_pkg::MAX_KEYS ? kvli_pkg::MAX_KEYS
                                                                     : active_keys);
        if (n == 1)
            return key_result(0, kvli_pkg::ST_SINGLE);
        if (t < key_time_tbl[0])
            return key_result(0, kvli_pkg::ST_CLAMP_LOW);
        seg = -1;
        for (int i = 0; i + 1 < n; i++)
        begin
            if (seg < 0 && t < key_time_tbl[i + 1])
                seg = i;
        end
        if (seg < 0)
            return key_result(n - 1, kvli_pkg::ST_CLAMP_HIGH);
        ts = key_time_tbl[seg];
        te = key_time_tbl[seg + 1];
        f = '0;
        if (te > ts && t > ts)
            f = 17'(({40'd0, t - ts} << kvli_pkg::FRAC_BITS) / {40'd0, te - ts});
        r.x = blend_comp(key_x_tbl[seg], key_x_tbl[seg + 1], f);
        r.y = blend_comp(key_y_tbl[seg], key_y_tbl[seg + 1], f);
        r.z = blend_comp(key_z_tbl[seg], key_z_tbl[seg + 1], f);
        r.seg = 6'(seg);
        r.status = kvli_pkg::ST_INTERP;
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [5:0] idx, input logic [23:0] t,
        input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b00, vz, vy, vx, t, idx};
        expected_q.push_back(predict_interp(op, idx, t, vx, vy, vz));
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain_outstanding();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_key_count(input int unsigned v);
        drain_outstanding();
        key_count_we <= 1'b1;
        key_count_wdata <= kvli_pkg::KEY_CNT_W'(v);
        @(posedge clk);
        key_count_we <= 1'b0;
        active_keys = v;
        @(posedge clk);
    endtask

    // queries only read keys below the count, all of which are written
    task automatic load_keys(input int n, input bit sorted);
        logic [23:0] t;
        t = 24'($urandom_range(0, 3000));
        for (int i = 0; i < n; i++)
        begin
            send_item(kvli_pkg::OP_WRITE, 6'(i), t, $urandom, $urandom, $urandom);
            if (sorted)
                t = t + 24'($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 4000));
            else
                t = 24'($urandom);
        end
    endtask

    function automatic logic [23:0] pick_query_time(input int n);
        int k;
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 4))
            0: return key_time_tbl[k];
            1: return key_time_tbl[k] - 24'(1);
            2: return 24'($urandom);
            default: return key_time_tbl[k] + 24'($urandom_range(0, 4000));
        endcase
    endfunction

    stim_row_t directed_rows[$];

    initial
    begin
        stim_row_t row;
        int n;
        int sent;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one key after reset: write of key 0, single-key answers, then writes of keys 1 to 3 and 63
        directed_rows.push_back('{kvli_pkg::OP_WRITE, 6'd0, 24'd100, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h0, 1, kvli_pkg::ST_WRITE_DONE, 6'd0});
        directed_rows.push_back('{kvli_pkg::OP_QUERY, 6'h3f, 24'hff_ffff, '1, '1, '1, 1,
                                  kvli_pkg::ST_SINGLE, 6'd0});
        directed_rows.push_back('{kvli_pkg::OP_QUERY, 6'd0, 24'd0, '0, '0, '0, 1,
                                  kvli_pkg::ST_SINGLE, 6'd0});
        directed_rows.push_back('{kvli_pkg::OP_WRITE, 6'd1, 24'd100, 32'h7fff_ffff,
                                  32'h8000_0000, 32'hffff_ffff, 1,
                                  kvli_pkg::ST_WRITE_DONE, 6'd1});
        directed_rows.push_back('{kvli_pkg::OP_WRITE, 6'd2, 24'd612, 32'h8000_0000,
                                  32'h0001_0000, 32'h0, 1, kvli_pkg::ST_WRITE_DONE, 6'd2});
        directed_rows.push_back('{kvli_pkg::OP_WRITE, 6'd3, 24'hff_ffff, 32'h7fff_ffff,
                                  32'h8000_0000, 32'h1234_5678, 1,
                                  kvli_pkg::ST_WRITE_DONE, 6'd3});
        directed_rows.push_back('{kvli_pkg::OP_WRITE, 6'h3f, 24'hff_ffff, '1, '1, '1, 1,
                                  kvli_pkg::ST_WRITE_DONE, 6'h3f});
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item(row.op, row.idx, row.t, row.vx, row.vy, row.vz);
            if (row.has_exp && (expected_q[$].status != row.exp_status ||
                                expected_q[$].seg != row.exp_seg))
                report_mismatch("directed row", i, 32'({row.exp_seg, row.exp_status}));
        end
        directed_rows.delete();

        // four keys: low clamp, zero-length segment, interpolation at extremes, high clamp
        set_key_count(4);
        directed_rows.push_back('{kvli_pkg::OP_QUERY, 6'd0, 24'd99, '0, '0, '0, 1,
                                  kvli_pkg::ST_CLAMP_LOW, 6'd0});
        directed_rows.push_back('{kvli_pkg::OP_QUERY, 6'd0, 24'd100, '0, '0, '0, 1,
                                  kvli_pkg::ST_INTERP, 6'd1});
        directed_rows.push_back('{kvli_pkg::OP_QUERY, 6'd0, 24'd356, '0, '0, '0, 1,
                                  kvli_pkg::ST_INTERP, 6'd1});
        directed_rows.push_back('{kvli_pkg::OP_QUERY, 6'd0, 24'd611, '0, '0, '0, 1,
                                  kvli_pkg::ST_INTERP, 6'd1});
        directed_rows.push_back('{kvli_pkg::OP_QUERY, 6'd0, 24'hff_fffe, '0, '0, '0, 1,
                                  kvli_pkg::ST_INTERP, 6'd2});
        directed_rows.push_back('{kvli_pkg::OP_QUERY, 6'd0, 24'hff_ffff, '0, '0, '0, 1,
                                  kvli_pkg::ST_CLAMP_HIGH, 6'd3});
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_item(row.op, row.idx, row.t, row.vx, row.vy, row.vz);
            if (row.has_exp && (expected_q[$].status != row.exp_status ||
                                expected_q[$].seg != row.exp_seg))
                report_mismatch("directed row", i, 32'({row.exp_seg, row.exp_status}));
        end

        // unsorted table: keys 1 and 2 get times below key 0, then two queries
        send_item(kvli_pkg::OP_WRITE, 6'd1, 24'd50, 32'h1, 32'h2, 32'h3);
        send_item(kvli_pkg::OP_WRITE, 6'd2, 24'd40, 32'h4, 32'h5, 32'h6);
        send_item(kvli_pkg::OP_QUERY, 6'd0, 24'd100, '0, '0, '0);
        send_item(kvli_pkg::OP_QUERY, 6'd0, 24'd45, '0, '0, '0);

        // zero count acts as one, maximum count with a full table
        set_key_count(0);
        send_item(kvli_pkg::OP_QUERY, 6'd0, 24'd7, '0, '0, '0);
        set_key_count(127);
        load_keys(kvli_pkg::MAX_KEYS, 1);
        send_item(kvli_pkg::OP_QUERY, 6'd0, 24'hff_ffff, '0, '0, '0);
        send_item(kvli_pkg::OP_QUERY, 6'd0, key_time_tbl[kvli_pkg::MAX_KEYS - 1] - 24'd1,
                  '0, '0, '0);

        // long hold-off on the result side while items keep coming
        hold_long = 1;
        for (int i = 0; i < 12; i++)
            send_item(kvli_pkg::OP_QUERY, 6'(i), pick_query_time(kvli_pkg::MAX_KEYS),
                      $urandom, $urandom, $urandom);
        hold_long = 0;
        drain_outstanding();

        sent = 0;
        while (sent < 450)
        begin
            case ($urandom_range(0, 5))
                0: n = kvli_pkg::MAX_KEYS;
                1: n = 2;
                default: n = $urandom_range(2, 10);
            endcase
            if (sent > 370)
                quiet_phase = 1;
            set_key_count($urandom_range(0, 9) == 0 ? $urandom_range(1, 64) : n);
            n = active_keys;
            if (n < 1)
                n = 1;
            load_keys(n, $urandom_range(0, 7) != 0);
            sent += n;
            repeat ($urandom_range(4, 25))
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(kvli_pkg::OP_WRITE, 6'($urandom_range(n, 63)), $urandom,
                              $urandom, $urandom, $urandom);
                else
                    send_item(kvli_pkg::OP_QUERY, 6'($urandom), pick_query_time(n),
                              $urandom, $urandom, $urandom);
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;
        ingress_done = 1;
    end

    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                m_axis_tready <= 1'b1;
                while (hold_long)
                    @(posedge clk);
            end
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 17);
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        interp_result_t got;
        interp_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tdata[101:96], m_axis_tuser};
            if (expected_q.size() == 0)
                report_mismatch("unexpected transaction", {29'd0, got.status}, 32'd0);
            else
            begin
                want = expected_q.pop_front();
                if (got.x !== want.x)
                    report_mismatch("out_x", got.x, want.x);
                if (got.y !== want.y)
                    report_mismatch("out_y", got.y, want.y);
                if (got.z !== want.z)
                    report_mismatch("out_z", got.z, want.z);
                if (got.seg !== want.seg)
                    report_mismatch("segment", {26'd0, got.seg}, {26'd0, want.seg});
                if (got.status !== want.status)
                    report_mismatch("status", {29'd0, got.status}, {29'd0, want.status});
            end
        end
    end

    initial
    begin
        wait (ingress_done);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
